// ----- rtl/core/mwma_pkg.sv -----
// ----------------------------------------------------------------------------
// mwma_pkg: shared definitions for the multichannel weighted moving average
// Sizes, widths, the sequencer state type and the control bundle that the
// sequencer hands to the datapath and the delay line store.
// ----------------------------------------------------------------------------
package mwma_pkg;

    // Filter geometry.
    localparam int WINDOW   = 8;
    localparam int CHANNELS = 4;

    // Field widths fixed by the interface.
    localparam int IDX_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 8;
    localparam int NUM_TAPS = 8;
    localparam int CFG_W    = NUM_TAPS * COEF_W;

    // Every tap weight is one after reset.
    localparam logic [CFG_W-1:0] COEF_RESET = {NUM_TAPS{COEF_W'(1)}};

    // Derived widths.
    localparam int WIN_LOG = $clog2(WINDOW);
    localparam int TAP_W   = (WINDOW > 1) ? WIN_LOG : 1;
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH   = CHANNELS * WINDOW;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W  = SAMPLE_W + COEF_W;
    localparam int ACC_W   = PROD_W + WIN_LOG;
    localparam int WSUM_W  = COEF_W + WIN_LOG;
    localparam int DVS_W   = WSUM_W;
    localparam int QUO_W   = ACC_W - 1;
    localparam int CNT_W   = $clog2(QUO_W);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_MAG,
        ST_DIV,
        ST_DONE
    } mwma_state_t;

    // Control bundle from the sequencer.
    typedef struct packed {
        logic             load;
        logic             mem_rd;
        logic             tap_mac;
        logic             last_tap;
        logic             mag_load;
        logic             div_step;
        logic             result_load;
        logic             bad_chan;
        logic [CH_W-1:0]  chan;
        logic [TAP_W-1:0] tap;
    } mwma_ctrl_t;

    // True when the channel index names an existing delay line.
    function automatic logic chan_ok(logic [IDX_W-1:0] idx);
        return int'(idx) < CHANNELS;
    endfunction

endpackage

// ----- rtl/core/mwma_if.sv -----
// ----------------------------------------------------------------------------
// mwma_if: channel interfaces of the weighted moving average
// Sample channel, result channel and coefficient write channel, each with a
// valid/ready handshake and a source and a sink modport.
// ----------------------------------------------------------------------------
interface mwma_in_if;
    import mwma_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [IDX_W-1:0]           sensor_index;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sensor_index, output sample, input ready);
    modport sink   (input valid, input sensor_index, input sample, output ready);
endinterface

interface mwma_out_if;
    import mwma_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered_value;
    logic                       saturated;
    logic                       zero_divisor;

    modport source (output valid, output filtered_value, output saturated,
                    output zero_divisor, input ready);
    modport sink   (input valid, input filtered_value, input saturated,
                    input zero_divisor, output ready);
endinterface

interface mwma_cfg_if;
    import mwma_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] coefficients;

    modport source (output valid, output coefficients, input ready);
    modport sink   (input valid, input coefficients, output ready);
endinterface

// ----- rtl/core/mwma_tap_mem.sv -----
// ----------------------------------------------------------------------------
// mwma_tap_mem: per-channel delay line store
// One memory of CHANNELS x WINDOW samples with a registered read. A valid bit
// per channel row makes a row that was never shifted since reset or since the
// last coefficient write read as zero.
// ----------------------------------------------------------------------------
module mwma_tap_mem (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 clear,
    input  logic                                 rd_en,
    input  logic                                 wr_en,
    input  logic                                 row_done,
    input  logic [mwma_pkg::CH_W-1:0]            chan,
    input  logic [mwma_pkg::TAP_W-1:0]           tap,
    input  logic signed [mwma_pkg::SAMPLE_W-1:0] wr_data,
    output logic signed [mwma_pkg::SAMPLE_W-1:0] rd_data
);
    import mwma_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] rd_raw_reg;
    logic                       rd_live_reg;
    logic                       rd_live_next;
    logic [CHANNELS-1:0]        row_valid_reg;
    logic [CHANNELS-1:0]        row_valid_next;

    // Row-major address: channel row, then tap position.
    assign addr = ADDR_W'(int'(chan) * WINDOW + int'(tap));

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[addr];
        end
    end

    // Row valid bits: cleared on a coefficient write, set after a full shift.
    always_comb
    begin
        row_valid_next = row_valid_reg;
        rd_live_next   = rd_live_reg;
        if (clear)
        begin
            row_valid_next = '0;
        end
        else if (row_done)
        begin
            row_valid_next[chan] = 1'b1;
        end
        if (rd_en)
        begin
            rd_live_next = row_valid_reg[chan];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_live_reg   <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            rd_live_reg   <= rd_live_next;
        end
    end

    // A row that holds no written samples reads as zero.
    assign rd_data = rd_live_reg ? rd_raw_reg : '0;

endmodule

// ----- rtl/core/mwma_alu.sv -----
// ----------------------------------------------------------------------------
// mwma_alu: shared adder/subtractor
// One signed add or subtract with a one-bit-wider result. It serves the
// multiply-accumulate, the magnitude step and every restoring divide step.
// ----------------------------------------------------------------------------
module mwma_alu (
    input  logic signed [mwma_pkg::ACC_W-1:0] a,
    input  logic signed [mwma_pkg::ACC_W-1:0] b,
    input  logic                              sub,
    output logic signed [mwma_pkg::ACC_W:0]   sum
);
    import mwma_pkg::*;

    localparam int SUM_W = ACC_W + 1;

    logic signed [SUM_W-1:0] a_ext;
    logic signed [SUM_W-1:0] b_ext;

    // Sign-extend both operands, then add or subtract in two's complement.
    assign a_ext = SUM_W'(a);
    assign b_ext = SUM_W'(b);
    assign sum   = a_ext + (sub ? ~b_ext : b_ext) + SUM_W'(sub);

endmodule

// ----- rtl/core/mwma_datapath.sv -----
// ----------------------------------------------------------------------------
// mwma_datapath: accumulate, divide and saturate
// Holds the coefficient register, the running weighted sum and weight sum,
// and a restoring divider that works one quotient bit per cycle on the
// shared adder. Forms the saturated result beat.
// ----------------------------------------------------------------------------
module mwma_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mwma_pkg::CFG_W-1:0]           cfg_data,
    input  logic signed [mwma_pkg::SAMPLE_W-1:0] in_sample,
    input  mwma_pkg::mwma_ctrl_t                 ctl,
    input  logic signed [mwma_pkg::SAMPLE_W-1:0] mem_rdata,
    output logic signed [mwma_pkg::SAMPLE_W-1:0] mem_wdata,
    output logic                                 wsum_zero,
    output logic signed [mwma_pkg::SAMPLE_W-1:0] filtered_value,
    output logic                                 saturated,
    output logic                                 zero_divisor
);
    import mwma_pkg::*;

    localparam logic [QUO_W-1:0] POS_LIM = QUO_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(2 ** (SAMPLE_W - 1));
    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

    logic [CFG_W-1:0]           coef_reg;
    logic signed [SAMPLE_W-1:0] carry_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [WSUM_W-1:0]   wsum_reg;
    logic [DVS_W-1:0]           dvs_reg;
    logic [DVS_W-1:0]           rem_reg;
    logic [QUO_W-1:0]           quo_reg;
    logic                       neg_reg;
    logic signed [SAMPLE_W-1:0] value_reg;
    logic                       sat_reg;
    logic                       zdiv_reg;

    logic signed [COEF_W-1:0]   weight;
    logic signed [PROD_W-1:0]   product;
    logic signed [ACC_W-1:0]    alu_a;
    logic signed [ACC_W-1:0]    alu_b;
    logic                       alu_sub;
    logic signed [ACC_W:0]      alu_sum;
    logic                       div_ge;
    logic [SAMPLE_W-1:0]        mag_low;
    logic signed [SAMPLE_W-1:0] value_next;
    logic                       sat_next;
    logic                       zdiv_next;

    // Coefficient register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else if (cfg_we)
        begin
            coef_reg <= cfg_data;
        end
    end

    // Weight of the current tap and its product with the sample in flight.
    assign weight  = coef_reg[COEF_W * int'(ctl.tap) +: COEF_W];
    assign product = weight * carry_reg;

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = ACC_W'(product);
        alu_sub = 1'b0;
        if (ctl.mag_load)
        begin
            alu_a   = '0;
            alu_b   = acc_reg;
            alu_sub = 1'b1;
        end
        else if (ctl.div_step)
        begin
            alu_a   = ACC_W'({rem_reg, quo_reg[QUO_W-1]});
            alu_b   = ACC_W'(dvs_reg);
            alu_sub = 1'b1;
        end
    end

    mwma_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    // The trial subtraction did not go negative.
    assign div_ge = !alu_sum[ACC_W];

    // Accumulation and division registers.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            carry_reg <= in_sample;
            acc_reg   <= '0;
            wsum_reg  <= '0;
        end
        if (ctl.tap_mac)
        begin
            acc_reg   <= alu_sum[ACC_W-1:0];
            wsum_reg  <= wsum_reg + WSUM_W'(weight);
            carry_reg <= mem_rdata;
        end
        if (ctl.mag_load)
        begin
            quo_reg <= acc_reg[ACC_W-1] ? alu_sum[QUO_W-1:0] : acc_reg[QUO_W-1:0];
            rem_reg <= '0;
            dvs_reg <= wsum_reg[WSUM_W-1] ? DVS_W'(-wsum_reg) : DVS_W'(wsum_reg);
            neg_reg <= acc_reg[ACC_W-1] ^ wsum_reg[WSUM_W-1];
        end
        if (ctl.div_step)
        begin
            rem_reg <= div_ge ? alu_sum[DVS_W-1:0]
                              : {rem_reg[DVS_W-2:0], quo_reg[QUO_W-1]};
            quo_reg <= {quo_reg[QUO_W-2:0], div_ge};
        end
        if (ctl.result_load)
        begin
            value_reg <= value_next;
            sat_reg   <= sat_next;
            zdiv_reg  <= zdiv_next;
        end
    end

    // Sign, saturation and the special cases of the result beat.
    assign mag_low = quo_reg[SAMPLE_W-1:0];

    always_comb
    begin
        value_next = '0;
        sat_next   = 1'b0;
        zdiv_next  = 1'b0;
        if (ctl.bad_chan)
        begin
            value_next = '0;
        end
        else if (wsum_zero)
        begin
            zdiv_next = 1'b1;
        end
        else if (neg_reg)
        begin
            if (quo_reg > NEG_LIM)
            begin
                value_next = S_MIN;
                sat_next   = 1'b1;
            end
            else
            begin
                value_next = SAMPLE_W'(-mag_low);
            end
        end
        else
        begin
            if (quo_reg > POS_LIM)
            begin
                value_next = S_MAX;
                sat_next   = 1'b1;
            end
            else
            begin
                value_next = mag_low;
            end
        end
    end

    assign wsum_zero      = (wsum_reg == '0);
    assign mem_wdata      = carry_reg;
    assign filtered_value = value_reg;
    assign saturated      = sat_reg;
    assign zero_divisor   = zdiv_reg;

endmodule

// ----- rtl/core/mwma_ctrl.sv -----
// ----------------------------------------------------------------------------
// mwma_ctrl: sequencer of the weighted moving average
// Walks one sample beat through the tap loop, the magnitude step and the
// divide steps, and owns the result beat's valid flag.
// ----------------------------------------------------------------------------
module mwma_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [mwma_pkg::IDX_W-1:0]     in_index,
    output logic                           in_ready,
    input  logic                           out_ready,
    output logic                           out_valid,
    input  logic                           wsum_zero,
    output mwma_pkg::mwma_ctrl_t           ctl
);
    import mwma_pkg::*;

    mwma_state_t      state_reg;
    mwma_state_t      state_next;
    logic [TAP_W-1:0] tap_reg;
    logic [TAP_W-1:0] tap_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CH_W-1:0]  chan_reg;
    logic [CH_W-1:0]  chan_next;
    logic             bad_reg;
    logic             bad_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic             last_tap;
    logic             last_step;
    logic             can_finish;

    assign last_tap   = (tap_reg == TAP_W'(WINDOW - 1));
    assign last_step  = (cnt_reg == CNT_W'(QUO_W - 1));
    assign can_finish = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = chan_ok(in_index) ? ST_READ : ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                state_next = last_tap ? ST_MAG : ST_READ;
            end
            ST_MAG:
            begin
                state_next = wsum_zero ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                state_next = last_step ? ST_DONE : ST_DIV;
            end
            ST_DONE:
            begin
                state_next = can_finish ? ST_IDLE : ST_DONE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        ctl.load        = (state_reg == ST_IDLE) && in_valid;
        ctl.mem_rd      = (state_reg == ST_READ);
        ctl.tap_mac     = (state_reg == ST_MAC);
        ctl.last_tap    = (state_reg == ST_MAC) && last_tap;
        ctl.mag_load    = (state_reg == ST_MAG);
        ctl.div_step    = (state_reg == ST_DIV);
        ctl.result_load = (state_reg == ST_DONE) && can_finish;
        ctl.bad_chan    = bad_reg;
        ctl.chan        = chan_reg;
        ctl.tap         = tap_reg;
    end

    // Tap and step counters, captured channel and result valid.
    always_comb
    begin
        tap_next       = tap_reg;
        cnt_next       = cnt_reg;
        chan_next      = chan_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg;
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            tap_next  = '0;
            chan_next = CH_W'(in_index);
            bad_next  = !chan_ok(in_index);
        end
        if ((state_reg == ST_MAC) && !last_tap)
        begin
            tap_next = tap_reg + TAP_W'(1);
        end
        if (state_reg == ST_MAG)
        begin
            cnt_next = '0;
        end
        if (state_reg == ST_DIV)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (ctl.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_reg       <= '0;
            cnt_reg       <= '0;
            chan_reg      <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            cnt_reg       <= cnt_next;
            chan_reg      <= chan_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A tap is multiplied right after its read, at the same position.
    a_mac_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> ($past(state_reg) == ST_READ) && (tap_reg == $past(tap_reg)))
        else $error("multiply step without a matching read");

    // The last tap leads straight to the magnitude step.
    a_last_tap_to_mag: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MAC) && last_tap) |=> (state_reg == ST_MAG))
        else $error("tap loop overran the window");

    // A regular quotient is only presented after the divide steps.
    a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && !bad_reg && !wsum_zero)
            |-> (($past(state_reg) == ST_DIV) || ($past(state_reg) == ST_DONE)))
        else $error("result formed without a completed division");

    // Loading a result always raises the result beat's valid.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.result_load |=> out_valid_reg)
        else $error("loaded result was not presented");

endmodule

// ----- rtl/core/multichannel_weighted_moving_average.sv -----
// ----------------------------------------------------------------------------
// multichannel_weighted_moving_average: weighted moving average over channels
// Keeps a WINDOW-deep delay line per channel and returns the coefficient
// weighted average of each channel's window for every sample beat.
// ----------------------------------------------------------------------------
// Each sample beat shifts into its channel's delay line (tap 0 is the newest
// sample) and yields one result beat: the sum of tap weight times sample
// divided by the sum of the weights, truncated toward zero and saturated to
// signed 16 bits, with flags for saturation and for a zero weight sum. One
// beat at a time is processed; samples is ready only while the sequencer is
// idle. From acceptance to the result register, each tap is first read
// through the registered single-address read of the delay line memory and
// then multiplied, followed by one magnitude step and one quotient bit per
// cycle from the shared adder; the result is formed once the result register
// is free. A zero weight sum skips the divide. The next sample is accepted
// in the cycle after the result is registered, while that result may still
// wait on results. A coefficient write takes effect at once and clears all
// delay lines through per-channel valid bits, so there is no clearing pass
// after reset or after a write.
// ----------------------------------------------------------------------------
module multichannel_weighted_moving_average (
    input  logic       clk,
    input  logic       rst_n,
    mwma_in_if.sink    samples,
    mwma_out_if.source results,
    mwma_cfg_if.sink   cfg
);
    import mwma_pkg::*;

    mwma_ctrl_t                 ctl;
    logic                       wsum_zero;
    logic signed [SAMPLE_W-1:0] mem_rdata;
    logic signed [SAMPLE_W-1:0] mem_wdata;

    // Coefficient writes are always taken.
    assign cfg.ready = 1'b1;

    // Sequencer.
    mwma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_index  (samples.sensor_index),
        .in_ready  (samples.ready),
        .out_ready (results.ready),
        .out_valid (results.valid),
        .wsum_zero (wsum_zero),
        .ctl       (ctl)
    );

    // Delay line store.
    mwma_tap_mem u_tap_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (cfg.valid),
        .rd_en    (ctl.mem_rd),
        .wr_en    (ctl.tap_mac),
        .row_done (ctl.last_tap),
        .chan     (ctl.chan),
        .tap      (ctl.tap),
        .wr_data  (mem_wdata),
        .rd_data  (mem_rdata)
    );

    // Arithmetic.
    mwma_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg.valid),
        .cfg_data       (cfg.coefficients),
        .in_sample      (samples.sample),
        .ctl            (ctl),
        .mem_rdata      (mem_rdata),
        .mem_wdata      (mem_wdata),
        .wsum_zero      (wsum_zero),
        .filtered_value (results.filtered_value),
        .saturated      (results.saturated),
        .zero_divisor   (results.zero_divisor)
    );

endmodule

// ----- tb/sv/mwma_average_checker.sv -----
// ----------------------------------------------------------------------------
// mwma_average_checker: result checker for the weighted moving average
// Watches the sample, result and coefficient channels, keeps its own copy of
// the per-channel delay lines and tap weights, predicts the average for every
// accepted sample beat and compares each result beat against the oldest one.
// ----------------------------------------------------------------------------
module mwma_average_checker (
    input  logic        clk,
    input  logic        rst_n,
    mwma_in_if          samples,
    mwma_out_if         results,
    mwma_cfg_if         cfg,
    output int unsigned samples_seen,
    output int unsigned pending,
    output int unsigned results_checked,
    output int unsigned sat_seen,
    output int unsigned zdiv_seen,
    output int unsigned fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import mwma_pkg::*;

    localparam int VALUE_MAX  = 2 ** (SAMPLE_W - 1) - 1;
    localparam int VALUE_MIN  = -(2 ** (SAMPLE_W - 1));
    localparam int REPORT_MAX = 10;

    // One expected result beat.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       saturated;
        logic                       zero_divisor;
    } average_t;

    // Mirror of the block state.
    logic [CFG_W-1:0]           weights;
    logic signed [SAMPLE_W-1:0] history [CHANNELS][WINDOW];
    average_t                   averages_due [$];

    // Shift a sample into its channel and form the truncated, saturated average.
    function automatic average_t shift_and_average(logic [IDX_W-1:0] ch,
                                                   logic signed [SAMPLE_W-1:0] s);
        average_t avg;
        int       acc;
        int       wsum;
        int       w;
        int       q;
        avg  = '0;
        acc  = 0;
        wsum = 0;
        // A channel past the last delay line gives a zero average without a state change.
        if (int'(ch) >= CHANNELS)
            return avg;
        for (int k = WINDOW - 1; k > 0; k--)
            history[ch][k] = history[ch][k-1];
        history[ch][0] = s;
        for (int k = 0; k < WINDOW; k++)
        begin
            w     = int'($signed(weights[COEF_W*k +: COEF_W]));
            wsum += w;
            acc  += w * int'(history[ch][k]);
        end
        // Weights that cancel out give a zero value and the divisor flag.
        if (wsum == 0)
        begin
            avg.zero_divisor = 1'b1;
            return avg;
        end
        q = acc / wsum;
        if (q > VALUE_MAX)
        begin
            q             = VALUE_MAX;
            avg.saturated = 1'b1;
        end
        else if (q < VALUE_MIN)
        begin
            q             = VALUE_MIN;
            avg.saturated = 1'b1;
        end
        avg.value = q[SAMPLE_W-1:0];
        return avg;
    endfunction

    // Track every handshake; counts go out as registered values.
    always @(posedge clk or negedge rst_n)
    begin
        average_t want;
        if (!rst_n)
        begin
            weights = COEF_RESET;
            foreach (history[c, k])
                history[c][k] = '0;
            averages_due.delete();
            samples_seen    <= 0;
            pending         <= 0;
            results_checked <= 0;
            sat_seen        <= 0;
            zdiv_seen       <= 0;
            fail_count      <= 0;
        end
        else
        begin
            // A coefficient write loads the weights and clears every delay line.
            if (cfg.valid && cfg.ready)
            begin
                weights = cfg.coefficients;
                foreach (history[c, k])
                    history[c][k] = '0;
            end

            if (samples.valid && samples.ready)
            begin
                averages_due.push_back(shift_and_average(samples.sensor_index,
                                                         samples.sample));
                samples_seen <= samples_seen + 1;
            end

            // Compare a result beat with the oldest expected average.
            if (results.valid && results.ready)
            begin
                results_checked <= results_checked + 1;
                if (averages_due.size() == 0)
                begin
                    if (fail_count < REPORT_MAX)
                        $display("[%0t] unexpected result beat: value %0d sat %0b zdiv %0b",
                                 $realtime, results.filtered_value, results.saturated,
                                 results.zero_divisor);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = averages_due.pop_front();
                    if (want.saturated)
                        sat_seen <= sat_seen + 1;
                    if (want.zero_divisor)
                        zdiv_seen <= zdiv_seen + 1;
                    if (results.filtered_value !== want.value ||
                        results.saturated !== want.saturated ||
                        results.zero_divisor !== want.zero_divisor)
                    begin
                        if (fail_count < REPORT_MAX)
                            $display("[%0t] result %0d mismatch: expected value %0d sat %0b zdiv %0b, got value %0d sat %0b zdiv %0b",
                                     $realtime, results_checked, want.value,
                                     want.saturated, want.zero_divisor,
                                     results.filtered_value, results.saturated,
                                     results.zero_divisor);
                        fail_count <= fail_count + 1;
                    end
                end
            end

            pending <= averages_due.size();
        end
    end

endmodule

// ----- tb/sv/multichannel_weighted_moving_average_test.sv -----
// ----------------------------------------------------------------------------
// multichannel_weighted_moving_average_test: top of the filter testbench
// Drives sample beats in random bursts, stalls the result channel on its own
// pattern and reprograms the tap weights between phases, from the reset
// weights through extreme, cancelling and random settings. A checker module
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module multichannel_weighted_moving_average_test;
    import mwma_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SETTINGS = 13;
    localparam int PHASE_ITEMS  = 72;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 4000;

    logic clk = 1'b0;
    logic rst_n;

    int unsigned items_sent       = 0;
    int unsigned burst_left       = 0;
    int unsigned settings_written = 0;

    int unsigned samples_seen;
    int unsigned pending;
    int unsigned results_checked;
    int unsigned sat_seen;
    int unsigned zdiv_seen;
    int unsigned fail_count;

    mwma_in_if  samples_ch ();
    mwma_out_if results_ch ();
    mwma_cfg_if cfg_ch ();

    multichannel_weighted_moving_average dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    mwma_average_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .samples         (samples_ch),
        .results         (results_ch),
        .cfg             (cfg_ch),
        .samples_seen    (samples_seen),
        .pending         (pending),
        .results_checked (results_checked),
        .sat_seen        (sat_seen),
        .zdiv_seen       (zdiv_seen),
        .fail_count      (fail_count)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Send one sample beat; a new burst may start with a random gap.
    task automatic send_sample(input logic [IDX_W-1:0] idx,
                               input logic signed [SAMPLE_W-1:0] value);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
            if (gap != 0)
            begin
                samples_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        samples_ch.valid        <= 1'b1;
        samples_ch.sensor_index <= idx;
        samples_ch.sample       <= value;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    // Wait until every sent beat has been predicted and its result has come.
    task automatic wait_drained();
        while (samples_seen != items_sent || pending != 0)
            @(posedge clk);
    endtask

    // Load new tap weights once the filter has gone idle.
    task automatic write_coefficients(input logic [CFG_W-1:0] value);
        samples_ch.valid <= 1'b0;
        wait_drained();
        cfg_ch.valid        <= 1'b1;
        cfg_ch.coefficients <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        burst_left    = 0;
        settings_written++;
    endtask

    // Result channel back pressure: long stalls, free runs and short chatter.
    initial
    begin : result_backpressure
        int unsigned hold;
        logic        level;
        hold  = 0;
        level = 1'b0;
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold == 0)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        level = 1'b0;
                        hold  = $urandom_range(1, 70);
                    end
                    1:
                    begin
                        level = 1'b1;
                        hold  = $urandom_range(50, 300);
                    end
                    default:
                    begin
                        level = 1'($urandom_range(0, 1));
                        hold  = $urandom_range(1, 6);
                    end
                endcase
            end
            hold--;
            results_ch.ready <= level;
        end
    end

    // Watchdog: end the run when no beat moves on any channel for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((samples_ch.valid && samples_ch.ready) ||
                (results_ch.valid && results_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        logic [CFG_W-1:0]           coef;
        logic signed [SAMPLE_W-1:0] value;
        int                         tap_sum;

        samples_ch.valid        <= 1'b0;
        samples_ch.sensor_index <= '0;
        samples_ch.sample       <= '0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.coefficients     <= '0;
        rst_n                   <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset weights: full-scale and small samples across every channel.
        repeat (4) send_sample(2'd0, 16'sh7FFF);
        repeat (4) send_sample(2'd1, -16'sh8000);
        send_sample(2'd2, 16'sh0000);
        send_sample(2'd2, -16'sh0001);
        send_sample(2'd2, 16'sh0001);
        send_sample(2'd2, 16'sh5555);
        send_sample(2'd3, 16'shAAAA);

        // Weights summing to one with large opposite taps force saturation.
        write_coefficients(64'h0000_0000_0000_827F);
        send_sample(2'd0, 16'sh7FFF);
        send_sample(2'd0, -16'sh8000);
        send_sample(2'd0, 16'sh7FFF);

        // Cancelling weights give a zero divisor.
        write_coefficients(64'hFF01_FF01_FF01_FF01);
        send_sample(2'd1, 16'sh04D2);
        send_sample(2'd1, -16'sh0001);

        // Random phases, one weight setting each.
        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            case (p)
                0: coef = COEF_RESET;
                1: coef = {NUM_TAPS{8'h7F}};
                2: coef = {NUM_TAPS{8'h80}};
                3: coef = '0;
                4: coef = {NUM_TAPS{8'hFF}};
                5: coef = 64'h0000_0000_0000_0001;
                6: coef = 64'h0000_0000_0000_827F;
                7: coef = 64'hFF01_FF01_FF01_FF01;
                default:
                begin
                    coef = {$urandom, $urandom};
                    // Pull the last tap so the weight sum lands near zero.
                    if (p % 2 == 0)
                    begin
                        tap_sum = 0;
                        for (int k = 0; k < NUM_TAPS - 1; k++)
                            tap_sum += int'($signed(coef[COEF_W*k +: COEF_W]));
                        tap_sum = -tap_sum + int'($urandom_range(0, 4)) - 2;
                        if (tap_sum > 127)
                            tap_sum = 127;
                        else if (tap_sum < -128)
                            tap_sum = -128;
                        coef[CFG_W-COEF_W +: COEF_W] = tap_sum[COEF_W-1:0];
                    end
                end
            endcase
            write_coefficients(coef);

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                case ($urandom_range(0, 7))
                    0: value = 16'sh7FFF;
                    1: value = -16'sh8000;
                    2: value = $urandom_range(0, 1) ? 16'sh0000 : -16'sh0001;
                    default: value = SAMPLE_W'($urandom);
                endcase
                send_sample(IDX_W'($urandom_range(0, 2 ** IDX_W - 1)), value);
            end
        end

        // Drain, then give the block time to show any stray result beat.
        samples_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d sample beats over %0d weight settings after reset weights",
                 items_sent, settings_written);
        $display("Checked %0d result beats: %0d saturated, %0d with a zero weight sum",
                 results_checked, sat_seen, zdiv_seen);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/mwma_pkg.sv
rtl/core/mwma_if.sv
rtl/core/mwma_tap_mem.sv
rtl/core/mwma_alu.sv
rtl/core/mwma_datapath.sv
rtl/core/mwma_ctrl.sv
rtl/core/multichannel_weighted_moving_average.sv
tb/sv/mwma_average_checker.sv
tb/sv/multichannel_weighted_moving_average_test.sv
